FILE: design/dse_pkg.sv
package dse_pkg;

  // Record class codes, shared by the input and result channels.
  localparam int CLASS_W = 2;
  localparam logic [CLASS_W-1:0] CLASS_NORMAL     = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_CANDIDATE  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_USED       = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_ELIMINATED = 2'd3;

  // Tolerance register and result index widths.
  localparam int TOL_W   = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;
  localparam int INDEX_W = 6;

  // Geometry of one record: two points of three axes.
  localparam int N_AXES        = 3;
  localparam int N_COORDS      = 2 * N_AXES;
  localparam int N_POINT_PAIRS = 4;
  localparam int N_DIFFS       = N_POINT_PAIRS * N_AXES;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_rec;   // store the accepted item at wr_addr
    logic latch_i;  // capture the record read at rd_addr as the reference record
    logic issue;    // start a comparison against the record read at rd_addr
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic class_cand;  // class read at rd_addr is candidate
    logic pipe_busy;   // a comparison is still in flight
  } status_t;

endpackage

FILE: design/dse_ram.sv
module dse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/dse_datapath.sv
module dse_datapath import dse_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  parameter int COORD_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [TOL_W-1:0]               cfg_data,
  input  cmd_t                           cmd,
  input  logic [$clog2(MAX_RECORDS)-1:0] wr_addr,
  input  logic [$clog2(MAX_RECORDS)-1:0] rd_addr,
  input  logic signed [COORD_BITS-1:0]   first_x,
  input  logic signed [COORD_BITS-1:0]   first_y,
  input  logic signed [COORD_BITS-1:0]   first_z,
  input  logic signed [COORD_BITS-1:0]   second_x,
  input  logic signed [COORD_BITS-1:0]   second_y,
  input  logic signed [COORD_BITS-1:0]   second_z,
  input  logic [CLASS_W-1:0]             class_in,
  output logic [CLASS_W-1:0]             class_rd,
  output status_t                        status
);

  localparam int AW     = $clog2(MAX_RECORDS);
  localparam int WORD_W = N_COORDS * COORD_BITS;
  localparam int CMP_W  = (COORD_BITS > TOL_W) ? COORD_BITS : TOL_W;
  localparam int SQ_W   = 2 * TOL_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int N_STG  = 6;
  localparam logic [COORD_BITS-1:0] SIGN_FLIP = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Pairs 0 and 1 compare end to end, pairs 2 and 3 compare reversed.
  function automatic int i_sel(input int p, input int a);
    return ((p == 0) || (p == 2)) ? a : N_AXES + a;
  endfunction

  function automatic int j_sel(input int p, input int a);
    return ((p == 0) || (p == 3)) ? a : N_AXES + a;
  endfunction

  logic [TOL_W-1:0]      tol;
  logic [SQ_W-1:0]       tol_sq;
  logic [COORD_BITS-1:0] coord_in [N_COORDS];
  logic [WORD_W-1:0]     rec_word;
  logic [WORD_W-1:0]     coord_rdata;
  logic [WORD_W-1:0]     rec_i;
  logic                  class_we;
  logic [AW-1:0]         class_waddr;
  logic [CLASS_W-1:0]    class_wdata;
  logic                  elim_we;

  logic [N_STG-1:0]      v;
  logic [AW-1:0]         ja [N_STG];
  logic [N_STG-1:1]      cand;
  logic [COORD_BITS-1:0] diff1 [N_DIFFS];
  logic [TOL_W-1:0]      d2 [N_DIFFS];
  logic [N_DIFFS-1:0]    lt2;
  logic [SQ_W-1:0]       sq3 [N_DIFFS];
  logic [N_DIFFS-1:0]    lt3;
  logic [SUM_W-1:0]      sxy4 [N_POINT_PAIRS];
  logic [SQ_W-1:0]       sz4 [N_POINT_PAIRS];
  logic [N_POINT_PAIRS-1:0] ok4;
  logic [N_POINT_PAIRS-1:0] m5;

  // Coordinates are stored in offset binary so differences are unsigned.
  assign coord_in[0] = first_x;
  assign coord_in[1] = first_y;
  assign coord_in[2] = first_z;
  assign coord_in[3] = second_x;
  assign coord_in[4] = second_y;
  assign coord_in[5] = second_z;

  always_comb begin
    for (int c = 0; c < N_COORDS; c++) begin
      rec_word[c*COORD_BITS +: COORD_BITS] = coord_in[c] ^ SIGN_FLIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_data;
    end
    tol_sq <= SQ_W'(tol) * SQ_W'(tol);
  end

  assign class_we    = cmd.wr_rec | elim_we;
  assign class_waddr = cmd.wr_rec ? wr_addr : ja[N_STG-1];
  assign class_wdata = cmd.wr_rec ? class_in : CLASS_ELIMINATED;

  dse_ram #(.WIDTH(WORD_W), .DEPTH(MAX_RECORDS)) u_coord_ram (
    .clk   (clk),
    .we    (cmd.wr_rec),
    .waddr (wr_addr),
    .wdata (rec_word),
    .raddr (rd_addr),
    .rdata (coord_rdata)
  );

  dse_ram #(.WIDTH(CLASS_W), .DEPTH(MAX_RECORDS)) u_class_ram (
    .clk   (clk),
    .we    (class_we),
    .waddr (class_waddr),
    .wdata (class_wdata),
    .raddr (rd_addr),
    .rdata (class_rd)
  );

  assign status.class_cand = (class_rd == CLASS_CANDIDATE);
  assign status.pipe_busy  = |v;

  always_ff @(posedge clk) begin
    if (cmd.latch_i) begin
      rec_i <= coord_rdata;
    end
  end

  // Comparison pipeline: read, difference, tolerance check, square, sums, compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[N_STG-2:0], cmd.issue};
    end
  end

  always_ff @(posedge clk) begin
    logic [COORD_BITS-1:0] a;
    logic [COORD_BITS-1:0] b;
    logic [CMP_W-1:0]      dx;
    ja[0]   <= rd_addr;
    for (int s = 1; s < N_STG; s++) begin
      ja[s] <= ja[s-1];
    end
    cand[1] <= status.class_cand;
    for (int s = 2; s < N_STG; s++) begin
      cand[s] <= cand[s-1];
    end
    for (int p = 0; p < N_POINT_PAIRS; p++) begin
      for (int x = 0; x < N_AXES; x++) begin
        a = rec_i[i_sel(p, x)*COORD_BITS +: COORD_BITS];
        b = coord_rdata[j_sel(p, x)*COORD_BITS +: COORD_BITS];
        diff1[p*N_AXES+x] <= (a > b) ? (a - b) : (b - a);
      end
    end
    for (int n = 0; n < N_DIFFS; n++) begin
      dx     = CMP_W'(diff1[n]);
      lt2[n] <= dx < CMP_W'(tol);
      d2[n]  <= dx[TOL_W-1:0];
      sq3[n] <= SQ_W'(d2[n]) * SQ_W'(d2[n]);
    end
    lt3 <= lt2;
    for (int p = 0; p < N_POINT_PAIRS; p++) begin
      sxy4[p] <= SUM_W'(sq3[p*N_AXES]) + SUM_W'(sq3[p*N_AXES+1]);
      sz4[p]  <= sq3[p*N_AXES+2];
      ok4[p]  <= &lt3[p*N_AXES +: N_AXES];
      m5[p]   <= ok4[p] && ((sxy4[p] + SUM_W'(sz4[p])) < SUM_W'(tol_sq));
    end
  end

  assign elim_we = v[N_STG-1] && cand[N_STG-1] && ((m5[0] && m5[1]) || (m5[2] && m5[3]));

  // An elimination is written only into a record that was a candidate.
  a_elim_cand: assert property (@(posedge clk) disable iff (rst)
    elim_we |-> cand[N_STG-1] && v[N_STG-1])
    else $error("elimination without a candidate record in the last stage");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_rec |-> !status.pipe_busy)
    else $error("record load while comparisons are in flight");

  a_busy_follows_issue: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> status.pipe_busy)
    else $error("issued comparison not tracked as busy");

endmodule

FILE: design/dse_ctrl.sv
module dse_ctrl import dse_pkg::*; #(
  parameter int MAX_RECORDS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           last_record,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [INDEX_W-1:0]             record_index,
  output logic                           last_result,
  output logic                           overflow,
  output cmd_t                           cmd,
  output logic [$clog2(MAX_RECORDS)-1:0] wr_addr,
  output logic [$clog2(MAX_RECORDS)-1:0] rd_addr,
  input  status_t                        status
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [6:0] {
    S_LOAD     = 7'b0000001,
    S_I_RD     = 7'b0000010,
    S_I_CHK    = 7'b0000100,
    S_J_RUN    = 7'b0001000,
    S_DRAIN    = 7'b0010000,
    S_EMIT_RD  = 7'b0100000,
    S_EMIT_OUT = 7'b1000000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          ovf, ovf_next;
  logic [AW-1:0] i, i_next;
  logic [AW-1:0] j, j_next;
  logic [AW-1:0] k, k_next;
  logic          accept;
  logic          full;
  logic [CW-1:0] i_plus1;
  logic          i_done;
  logic          j_last;
  logic          k_last;

  assign in_ready     = (state == S_LOAD);
  assign out_valid    = (state == S_EMIT_OUT);
  assign accept       = in_valid && in_ready;
  assign full         = (cnt == CW'(MAX_RECORDS));
  assign wr_addr      = cnt[AW-1:0];
  assign i_plus1      = CW'(i) + CW'(1);
  assign i_done       = i_plus1 >= (cnt - CW'(1));
  assign j_last       = (CW'(j) + CW'(1)) == cnt;
  assign k_last       = (CW'(k) + CW'(1)) == cnt;
  assign record_index = INDEX_W'(k);
  assign last_result  = k_last;
  assign overflow     = ovf;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ovf_next   = ovf;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    cmd        = '0;
    rd_addr    = i;
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_next = 1'b1;
          end else begin
            cmd.wr_rec = 1'b1;
            cnt_next   = cnt + CW'(1);
          end
          if (last_record) begin
            i_next     = '0;
            state_next = S_I_RD;
          end
        end
      end
      S_I_RD: begin
        state_next = S_I_CHK;
      end
      S_I_CHK: begin
        cmd.latch_i = 1'b1;
        if (status.class_cand && (i_plus1 < cnt)) begin
          j_next     = i_plus1[AW-1:0];
          state_next = S_J_RUN;
        end else if (i_done) begin
          k_next     = '0;
          state_next = S_EMIT_RD;
        end else begin
          i_next     = i + AW'(1);
          state_next = S_I_RD;
        end
      end
      S_J_RUN: begin
        rd_addr   = j;
        cmd.issue = 1'b1;
        if (j_last) begin
          state_next = S_DRAIN;
        end else begin
          j_next = j + AW'(1);
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          if (i_done) begin
            k_next     = '0;
            state_next = S_EMIT_RD;
          end else begin
            i_next     = i + AW'(1);
            state_next = S_I_RD;
          end
        end
      end
      S_EMIT_RD: begin
        rd_addr    = k;
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        rd_addr = k;
        if (out_ready) begin
          if (k_last) begin
            cnt_next   = '0;
            ovf_next   = 1'b0;
            k_next     = '0;
            state_next = S_LOAD;
          end else begin
            k_next     = k + AW'(1);
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      ovf   <= 1'b0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ovf   <= ovf_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !status.pipe_busy)
    else $error("loading while comparisons are in flight");

  a_issue_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (CW'(j) < cnt) && (j > i))
    else $error("comparison issued outside the loaded table");

  a_latch_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_i |-> !status.pipe_busy)
    else $error("reference record replaced during comparisons");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(k) && $stable(ovf))
    else $error("stalled result changed");

endmodule

FILE: design/duplicate_segment_eliminator_core.sv
// Duplicate segment eliminator.
// Items arrive on the input channel (in_valid/in_ready), one segment record
// per item: two endpoints in signed Q16.16 and a class. Items are taken
// only while the block is loading. An item marked last_record closes the
// table: the block stops accepting items, compares every candidate record
// with each later candidate and marks later duplicates as eliminated.
// Elimination reads each stored record but the last as a reference in turn;
// for each candidate it streams every later record into the comparison
// pipeline, then waits for the pipeline to drain. During that stream pairs
// enter at one pair per cycle, a rate set by the single read port of the
// record memory.
// Results then leave on the output channel (out_valid/out_ready), one per
// stored record in table order; each is read before it is offered. A stalled
// receiver simply holds the current result; nothing is lost. After the last
// result the table is empty again and loading resumes. Reset clears the
// record count, the overflow flag and the controller, sets match_tolerance
// to its default; the record memories are not cleared. The user writes
// match_tolerance via cfg_we/cfg_data only while idle; it is not enforced.
module duplicate_segment_eliminator_core import dse_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  parameter int COORD_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [TOL_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  input  logic signed [COORD_BITS-1:0] first_z,
  input  logic signed [COORD_BITS-1:0] second_x,
  input  logic signed [COORD_BITS-1:0] second_y,
  input  logic signed [COORD_BITS-1:0] second_z,
  input  logic [CLASS_W-1:0]           class_in,
  input  logic                         last_record,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [INDEX_W-1:0]           record_index,
  output logic [CLASS_W-1:0]           class_out,
  output logic                         last_result,
  output logic                         overflow
);

  localparam int AW = $clog2(MAX_RECORDS);

  // Command and status between the sequencer and the record datapath.
  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // The sequencer owns the record count, the loop indices and both
  // handshakes. It walks the reference index i over the table and streams
  // every later index j into the comparison pipeline, then waits for the
  // pipeline to drain so that the next reference record sees all updates.
  dse_ctrl #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_record  (last_record),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .record_index (record_index),
    .last_result  (last_result),
    .overflow     (overflow),
    .cmd          (cmd),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .status       (status)
  );

  // The datapath holds the record memories, the tolerance register and the
  // pipelined distance test. Its class memory read port also supplies the
  // class of each result, held in the memory's read register while the
  // receiver stalls.
  dse_datapath #(.MAX_RECORDS(MAX_RECORDS), .COORD_BITS(COORD_BITS)) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .first_x  (first_x),
    .first_y  (first_y),
    .first_z  (first_z),
    .second_x (second_x),
    .second_y (second_y),
    .second_z (second_z),
    .class_in (class_in),
    .class_rd (class_out),
    .status   (status)
  );

endmodule

FILE: tb/sv/testbench.sv
module testbench import dse_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Table geometry of the block as built here.
  localparam int MAX_RECS = 64;
  localparam int COORD_W  = 32;

  // Cycles allowed after the last result before the block counts as idle, the
  // length of the long receiver hold-off, and the hard limit on the run.
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // One segment record as it is offered on the input channel.
  typedef struct {
    point_t              first;
    point_t              second;
    logic [CLASS_W-1:0]  cls;
    logic                last;
  } segment_t;

  // One result as it should leave the output channel.
  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [CLASS_W-1:0] cls;
    logic               last;
    logic               ovf;
  } class_result_t;

  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t ONE   = 32'sd65536;  // 1.0 in Q16.16

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [TOL_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_ready;
  coord_t              first_x;
  coord_t              first_y;
  coord_t              first_z;
  coord_t              second_x;
  coord_t              second_y;
  coord_t              second_z;
  logic [CLASS_W-1:0]  class_in;
  logic                last_record;
  logic                out_valid;
  logic                out_ready;
  logic [INDEX_W-1:0]  record_index;
  logic [CLASS_W-1:0]  class_out;
  logic                last_result;
  logic                overflow;

  duplicate_segment_eliminator_core #(
    .MAX_RECORDS (MAX_RECS),
    .COORD_BITS  (COORD_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_x      (first_x),
    .first_y      (first_y),
    .first_z      (first_z),
    .second_x     (second_x),
    .second_y     (second_y),
    .second_z     (second_z),
    .class_in     (class_in),
    .last_record  (last_record),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .record_index (record_index),
    .class_out    (class_out),
    .last_result  (last_result),
    .overflow     (overflow)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The testbench's own picture of the block: the table being loaded, the
  // overflow flag of that table and the tolerance register.
  segment_t         seg_table [MAX_RECS];
  int               seg_count;
  logic             seg_dropped;
  logic [TOL_W-1:0] tolerance;

  // Results the block still owes us, oldest first.
  class_result_t class_expect [$];

  int  error_count;
  int  cycle_count;
  bit  idle_on;       // random gaps and stalls on both channels
  bit  hold_request;  // asks the receiver for one long hold-off

  // Distance along one axis. The inputs are 32-bit two's complement, so the
  // difference fits easily into 64 bits and is never negative after the abs.
  function automatic logic [63:0] axis_gap(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Two points match when every axis gap is below the tolerance and the
  // squared Euclidean distance is strictly below the squared tolerance. With
  // each gap below 2^31 the sum of the three squares cannot overflow 64 bits.
  function automatic bit ends_match(point_t a, point_t b);
    logic [63:0] tol;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] dz;
    tol = {33'd0, tolerance};
    dx  = axis_gap(a.x, b.x);
    dy  = axis_gap(a.y, b.y);
    dz  = axis_gap(a.z, b.z);
    if (dx >= tol || dy >= tol || dz >= tol) begin
      return 1'b0;
    end
    return (dx * dx + dy * dy + dz * dz) < (tol * tol);
  endfunction

  // Runs the elimination pass over the loaded table in record order and queues
  // one result per stored record. An eliminated record never eliminates
  // anything itself, since the outer walk skips every non-candidate.
  function automatic void resolve_table();
    int            i;
    int            j;
    bit            same_way;
    bit            flipped;
    class_result_t r;
    for (i = 0; i < seg_count; i++) begin
      if (seg_table[i].cls != CLASS_CANDIDATE) continue;
      for (j = i + 1; j < seg_count; j++) begin
        if (seg_table[j].cls != CLASS_CANDIDATE) continue;
        same_way = ends_match(seg_table[i].first, seg_table[j].first) &&
                   ends_match(seg_table[i].second, seg_table[j].second);
        flipped  = ends_match(seg_table[i].first, seg_table[j].second) &&
                   ends_match(seg_table[i].second, seg_table[j].first);
        if (same_way || flipped) begin
          seg_table[j].cls = CLASS_ELIMINATED;
        end
      end
    end
    for (i = 0; i < seg_count; i++) begin
      r.index = INDEX_W'(i);
      r.cls   = seg_table[i].cls;
      r.last  = (i == seg_count - 1);
      r.ovf   = seg_dropped;
      class_expect.push_back(r);
    end
    seg_count   = 0;
    seg_dropped = 1'b0;
  endfunction

  // Called for every accepted item. A record that finds the table full is
  // dropped and only marks the table as overflowed; a last marker on such a
  // record still closes the table.
  function automatic void absorb_segment(segment_t s);
    if (seg_count < MAX_RECS) begin
      seg_table[seg_count] = s;
      seg_count++;
    end else begin
      seg_dropped = 1'b1;
    end
    if (s.last) begin
      resolve_table();
    end
  endfunction

  function automatic segment_t seg_of(coord_t fx, coord_t fy, coord_t fz,
                                      coord_t sx, coord_t sy, coord_t sz,
                                      logic [CLASS_W-1:0] cls, logic last);
    segment_t s;
    s.first.x  = fx;
    s.first.y  = fy;
    s.first.z  = fz;
    s.second.x = sx;
    s.second.y = sy;
    s.second.z = sz;
    s.cls      = cls;
    s.last     = last;
    return s;
  endfunction

  // Moves a coordinate by a random amount in [-r, r]. Near the ends of the
  // range this wraps, which simply gives a far-away point.
  function automatic coord_t nudge(coord_t c, int unsigned r);
    return c + coord_t'($urandom_range(0, 2 * r)) - coord_t'(r);
  endfunction

  // Random record. Most records are near copies of a record already in the
  // table, sometimes with the ends swapped, so that real duplicates turn up
  // often; the rest are random over the whole coordinate range.
  function automatic segment_t make_segment(logic last);
    segment_t    s;
    segment_t    src;
    int unsigned r;
    if (seg_count > 0 && $urandom_range(0, 9) < 6) begin
      src = seg_table[$urandom_range(0, seg_count - 1)];
      s   = src;
      if ($urandom_range(0, 1) == 1) begin
        s.first  = src.second;
        s.second = src.first;
      end
      r = (tolerance > 31'd1048576) ? 1048576 : int'(tolerance);
      case ($urandom_range(0, 3))
        0: begin
          r = 0;
        end
        1: begin
          r = r / 2;
        end
        default: begin
        end
      endcase
      s.first.x  = nudge(s.first.x, r);
      s.first.y  = nudge(s.first.y, r);
      s.first.z  = nudge(s.first.z, r);
      s.second.x = nudge(s.second.x, r);
      s.second.y = nudge(s.second.y, r);
      s.second.z = nudge(s.second.z, r);
    end else begin
      s.first.x  = $urandom;
      s.first.y  = $urandom;
      s.first.z  = $urandom;
      s.second.x = $urandom;
      s.second.y = $urandom;
      s.second.z = $urandom;
    end
    s.cls  = ($urandom_range(0, 9) < 7) ? CLASS_CANDIDATE : CLASS_W'($urandom_range(0, 3));
    s.last = last;
    return s;
  endfunction

  // Offers one item and waits for it to be taken. Inputs change only at the
  // falling edge; acceptance is judged at the rising edge. Valid stays high
  // from one item to the next unless a gap is inserted.
  task automatic send_segment(segment_t s);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    first_x     <= s.first.x;
    first_y     <= s.first.y;
    first_z     <= s.first.z;
    second_x    <= s.second.x;
    second_y    <= s.second.y;
    second_z    <= s.second.z;
    class_in    <= s.cls;
    last_record <= s.last;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    absorb_segment(s);
  endtask

  task automatic send_table(int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_segment(make_segment(k == n - 1));
    end
  endtask

  // Mostly short tables so the quadratic elimination stays cheap, with the
  // occasional longer one.
  function automatic int table_size();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
  endfunction

  // Stops offering items, waits for every owed result and then waits out
  // DRAIN_CYCLES so that the block can return to loading.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (class_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    tolerance = value;
  endtask

  // Hand-built table at the reset tolerance of 66: exact, reversed and near
  // copies just inside and just outside the limit on one axis and just inside
  // it on the diagonal, copies of other classes that must not take part, points
  // at the ends of the coordinate range, and a chain in which B and C each match
  // A but not each other, so A eliminates both.
  task automatic test_default_tolerance();
    send_segment(seg_of(0, 0, 0, ONE, 0, 0, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(0, 0, 0, ONE, 0, 0, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(ONE, 0, 0, 0, 0, 0, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(65, 0, 0, ONE, 0, 0, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(66, 0, 0, ONE, 0, 0, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(38, 38, 38, ONE, 0, 0, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(0, 40, -40, ONE, -40, 0, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(0, 0, 0, ONE, 0, 0, CLASS_NORMAL, 1'b0));
    send_segment(seg_of(0, 0, 0, ONE, 0, 0, CLASS_USED, 1'b0));
    send_segment(seg_of(0, 0, 0, ONE, 0, 0, CLASS_ELIMINATED, 1'b0));
    send_segment(seg_of(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(-ONE, 60, 0, 0, 0, ONE, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(-ONE, 0, 0, 0, 0, ONE, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(-ONE, 120, 0, 0, 0, ONE, CLASS_CANDIDATE, 1'b1));
    // A table of one record, and one that ends on a non-candidate.
    send_segment(seg_of(C_MAX, 0, C_MIN, 0, C_MAX, -1, CLASS_CANDIDATE, 1'b1));
    send_segment(seg_of(5, 5, 5, -5, -5, -5, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(5, 5, 5, -5, -5, -5, CLASS_USED, 1'b1));
  endtask

  // Zero tolerance matches nothing, not even identical points. The largest
  // tolerance matches across most of the range but not end to end.
  task automatic test_tolerance_extremes();
    write_tolerance('0);
    send_segment(seg_of(7, -7, 7, ONE, ONE, ONE, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(7, -7, 7, ONE, ONE, ONE, CLASS_CANDIDATE, 1'b1));
    write_tolerance({TOL_W{1'b1}});
    send_segment(seg_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(32'shC000_0000, 32'shC000_0000, 32'shC000_0000,
                        32'shC000_0000, 32'shC000_0000, 32'shC000_0000,
                        CLASS_CANDIDATE, 1'b0));
    send_segment(seg_of(32'shFFFF_FFFE, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                        CLASS_CANDIDATE, 1'b1));
  endtask

  // A table that fills exactly, then one whose last two records, the last
  // marker among them, find it full and are dropped.
  task automatic test_table_overflow();
    write_tolerance(TOL_W'($urandom_range(1, 4000)));
    send_table(MAX_RECS);
    send_table(MAX_RECS + 2);
  endtask

  // Random tables under a range of tolerances, ending at the reset value.
  // A tolerance of one only lets exact copies match.
  task automatic test_random_tables();
    logic [TOL_W-1:0] setting [5];
    int               s;
    int               sent;
    int               n;
    setting[0] = 1;
    setting[1] = TOL_W'($urandom_range(2, 5000));
    setting[2] = TOL_W'(ONE);
    setting[3] = TOL_W'($urandom);
    setting[4] = TOL_RESET;
    for (s = 0; s < 5; s++) begin
      write_tolerance(setting[s]);
      sent = 0;
      while (sent < 4) begin
        n = table_size();
        send_table(n);
        sent += n;
      end
    end
  endtask

  // The receiver stops for a long time while tables keep coming, so the
  // block holds its results and has to refuse further items.
  task automatic test_receiver_hold();
    int k;
    hold_request = 1'b1;
    for (k = 0; k < 3; k++) begin
      send_table($urandom_range(3, 10));
    end
    wait_idle();
  endtask

  // The closing stretch runs both channels without any gaps or stalls.
  task automatic test_full_rate();
    int sent;
    int n;
    idle_on = 1'b0;
    sent = 0;
    while (sent < 12) begin
      n = $urandom_range(1, 12);
      send_table(n);
      sent += n;
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, otherwise
  // always ready. out_ready only changes at the falling edge.
  initial begin
    int held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every result taken by the receiver is checked against the oldest owed
  // result, field by field.
  always @(posedge clk) begin
    class_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (class_expect.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: index %0d class %0d last %0d overflow %0d",
                   record_index, class_out, last_result, overflow);
        end
      end else begin
        want = class_expect.pop_front();
        if (record_index !== want.index || class_out !== want.cls ||
            last_result !== want.last || overflow !== want.ovf) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result mismatch: expected index %0d class %0d last %0d overflow %0d",
                     want.index, want.cls, want.last, want.ovf);
            $display("                 actual   index %0d class %0d last %0d overflow %0d",
                     record_index, class_out, last_result, overflow);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or results that never come end the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    first_x      = '0;
    first_y      = '0;
    first_z      = '0;
    second_x     = '0;
    second_y     = '0;
    second_z     = '0;
    class_in     = CLASS_NORMAL;
    last_record  = 1'b0;
    seg_count    = 0;
    seg_dropped  = 1'b0;
    tolerance    = TOL_RESET;
    error_count  = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_tolerance();
    test_tolerance_extremes();
    test_table_overflow();
    test_random_tables();
    test_receiver_hold();
    test_full_rate();
    wait_idle();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
